// File: hw/rtl/ealu_pkg.sv
// ----------------------------------------------------------------------------
// ealu_pkg
// Shared command codes, flag bit positions and helpers for the 8-bit ALU.
// ----------------------------------------------------------------------------
package ealu_pkg;

  localparam int unsigned DataW = 8;
  localparam int unsigned CmdW  = 5;

  typedef logic [DataW-1:0] byte_t;

  // Command codes; unused codes act as a no-op
  typedef enum logic [CmdW-1:0] {
    CMD_ADD  = 5'd0,
    CMD_ADC  = 5'd1,
    CMD_SUB  = 5'd2,
    CMD_SBC  = 5'd3,
    CMD_AND  = 5'd4,
    CMD_XOR  = 5'd5,
    CMD_OR   = 5'd6,
    CMD_CP   = 5'd7,
    CMD_INC  = 5'd8,
    CMD_DEC  = 5'd9,
    CMD_RLC  = 5'd10,
    CMD_RRC  = 5'd11,
    CMD_RL   = 5'd12,
    CMD_RR   = 5'd13,
    CMD_SLA  = 5'd14,
    CMD_SRA  = 5'd15,
    CMD_SLL  = 5'd16,
    CMD_SRL  = 5'd17,
    CMD_RLCA = 5'd18,
    CMD_RRCA = 5'd19,
    CMD_RLA  = 5'd20,
    CMD_RRA  = 5'd21
  } cmd_t;

  // Shift/rotate kinds, shared by the CB group and the accumulator group
  typedef enum logic [2:0] {
    ROT_RLC = 3'd0,
    ROT_RRC = 3'd1,
    ROT_RL  = 3'd2,
    ROT_RR  = 3'd3,
    ROT_SLA = 3'd4,
    ROT_SRA = 3'd5,
    ROT_SLL = 3'd6,
    ROT_SRL = 3'd7
  } rot_t;

  // Flag bit positions: S Z 5 H 3 P/V N C
  localparam int unsigned FlagS = 7;
  localparam int unsigned FlagZ = 6;
  localparam int unsigned Flag5 = 5;
  localparam int unsigned FlagH = 4;
  localparam int unsigned Flag3 = 3;
  localparam int unsigned FlagP = 2;
  localparam int unsigned FlagN = 1;
  localparam int unsigned FlagC = 0;

  // Even parity: 1 when the count of set bits is even
  function automatic logic even_par(input byte_t v);
    return ~(^v);
  endfunction

  // S, Z, 5, 3 and parity from a result; H, N, C cleared
  function automatic byte_t szp(input byte_t r);
    byte_t f;
    f        = '0;
    f[FlagS] = r[7];
    f[FlagZ] = (r == '0);
    f[Flag5] = r[5];
    f[Flag3] = r[3];
    f[FlagP] = even_par(r);
    return f;
  endfunction

endpackage

// File: hw/rtl/ealu_core.sv
// ----------------------------------------------------------------------------
// ealu_core
// Combinational datapath: one command in, new value and flag byte out.
// ----------------------------------------------------------------------------
module ealu_core (
  input  logic [ealu_pkg::CmdW-1:0] command,
  input  ealu_pkg::byte_t           acc_value,
  input  ealu_pkg::byte_t           operand,
  input  ealu_pkg::byte_t           flags_in,
  output ealu_pkg::byte_t           result,
  output ealu_pkg::byte_t           flags_out
);
  import ealu_pkg::*;

  // Adder / subtractor shared by ADD, ADC, SUB, SBC and CP
  logic        is_sub;
  logic        cin_use;
  logic        ci;
  byte_t       bb;
  logic [8:0]  full;
  logic [4:0]  half;
  byte_t       as_r;
  byte_t       as_f;

  always_comb begin
    is_sub  = (command == CMD_SUB) || (command == CMD_SBC) || (command == CMD_CP);
    cin_use = ((command == CMD_ADC) || (command == CMD_SBC)) & flags_in[FlagC];
    bb      = is_sub ? ~operand : operand;
    ci      = cin_use ^ is_sub;
    full    = {1'b0, acc_value} + {1'b0, bb} + {8'd0, ci};
    half    = {1'b0, acc_value[3:0]} + {1'b0, bb[3:0]} + {4'd0, ci};
    as_r    = full[7:0];
    as_f        = '0;
    as_f[FlagS] = as_r[7];
    as_f[FlagZ] = (as_r == '0);
    as_f[Flag5] = as_r[5];
    as_f[FlagH] = half[4] ^ is_sub;
    as_f[Flag3] = as_r[3];
    as_f[FlagP] = ~(acc_value[7] ^ bb[7]) & (acc_value[7] ^ as_r[7]);
    as_f[FlagN] = is_sub;
    as_f[FlagC] = full[8] ^ is_sub;
  end

  // Shifter for the CB group and the accumulator rotates
  logic  acc_rot;
  rot_t  kind;
  byte_t src;
  logic  out_bit;
  byte_t sh_r;

  always_comb begin
    acc_rot = (command >= CMD_RLCA);
    kind    = acc_rot ? rot_t'(command - CMD_RLCA) : rot_t'(command - CMD_RLC);
    src     = acc_rot ? acc_value : operand;
    out_bit = kind[0] ? src[0] : src[7];
    case (kind)
      ROT_RLC: sh_r = {src[6:0], src[7]};
      ROT_RRC: sh_r = {src[0], src[7:1]};
      ROT_RL:  sh_r = {src[6:0], flags_in[FlagC]};
      ROT_RR:  sh_r = {flags_in[FlagC], src[7:1]};
      ROT_SLA: sh_r = {src[6:0], 1'b0};
      ROT_SRA: sh_r = {src[7], src[7:1]};
      ROT_SLL: sh_r = {src[6:0], 1'b1};
      default: sh_r = {1'b0, src[7:1]};
    endcase
  end

  // Increment / decrement of the operand
  byte_t inc_r;
  byte_t dec_r;
  assign inc_r = operand + 8'd1;
  assign dec_r = operand - 8'd1;

  // Result and flag select
  always_comb begin
    result    = acc_value;
    flags_out = flags_in;
    case (command)
      CMD_ADD, CMD_ADC, CMD_SUB, CMD_SBC: begin
        result    = as_r;
        flags_out = as_f;
      end
      CMD_CP: begin
        flags_out        = as_f;
        flags_out[Flag5] = operand[5];
        flags_out[Flag3] = operand[3];
      end
      CMD_AND: begin
        result           = acc_value & operand;
        flags_out        = szp(acc_value & operand);
        flags_out[FlagH] = 1'b1;
      end
      CMD_XOR: begin
        result    = acc_value ^ operand;
        flags_out = szp(acc_value ^ operand);
      end
      CMD_OR: begin
        result    = acc_value | operand;
        flags_out = szp(acc_value | operand);
      end
      CMD_INC: begin
        result           = inc_r;
        flags_out        = szp(inc_r);
        flags_out[FlagH] = (inc_r[3:0] == 4'h0);
        flags_out[FlagP] = (inc_r == 8'h80);
        flags_out[FlagC] = flags_in[FlagC];
      end
      CMD_DEC: begin
        result           = dec_r;
        flags_out        = szp(dec_r);
        flags_out[FlagH] = (dec_r[3:0] == 4'hf);
        flags_out[FlagP] = (dec_r == 8'h7f);
        flags_out[FlagN] = 1'b1;
        flags_out[FlagC] = flags_in[FlagC];
      end
      CMD_RLC, CMD_RRC, CMD_RL, CMD_RR, CMD_SLA, CMD_SRA, CMD_SLL, CMD_SRL: begin
        result           = sh_r;
        flags_out        = szp(sh_r);
        flags_out[FlagC] = out_bit;
      end
      CMD_RLCA, CMD_RRCA, CMD_RLA, CMD_RRA: begin
        result           = sh_r;
        flags_out        = '0;
        flags_out[FlagS] = flags_in[FlagS];
        flags_out[FlagZ] = flags_in[FlagZ];
        flags_out[FlagP] = flags_in[FlagP];
        flags_out[Flag5] = sh_r[5];
        flags_out[Flag3] = sh_r[3];
        flags_out[FlagC] = out_bit;
      end
      default: begin
        result    = acc_value;
        flags_out = flags_in;
      end
    endcase
  end

endmodule

// File: hw/rtl/eight_bit_alu_with_flags.sv
// ----------------------------------------------------------------------------
// eight_bit_alu_with_flags
// 8-bit ALU with a Z80-style flag byte, one operation per beat.
// ----------------------------------------------------------------------------
// A beat is taken at every clock edge where start is high; busy is always
// low, so a new beat may follow in every cycle. Each beat gives exactly one
// result: the operands land in an input register, the combinational ALU
// datapath works on them, and the value and flag byte are registered
// with a one-cycle done strobe. The receiver cannot stall, so results must
// be captured in the cycle that done is high.
module eight_bit_alu_with_flags (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  output logic                      busy,
  input  logic [ealu_pkg::CmdW-1:0] command,
  input  ealu_pkg::byte_t           acc_value,
  input  ealu_pkg::byte_t           operand,
  input  ealu_pkg::byte_t           flags_in,
  output logic                      done,
  output ealu_pkg::byte_t           result,
  output ealu_pkg::byte_t           flags_out
);
  import ealu_pkg::*;

  // Pipeline never stalls
  assign busy = 1'b0;

  // Input register
  logic               in_valid;
  logic [CmdW-1:0]    cmd_q;
  byte_t              acc_q;
  byte_t              opd_q;
  byte_t              flg_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      in_valid <= start & ~busy;
    end
  end

  always_ff @(posedge clk) begin
    if (start & ~busy) begin
      cmd_q <= command;
      acc_q <= acc_value;
      opd_q <= operand;
      flg_q <= flags_in;
    end
  end

  // Datapath
  byte_t res_next;
  byte_t flg_next;

  ealu_core u_core (
    .command   (cmd_q),
    .acc_value (acc_q),
    .operand   (opd_q),
    .flags_in  (flg_q),
    .result    (res_next),
    .flags_out (flg_next)
  );

  // Result register with one-cycle strobe
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid) begin
      result    <= res_next;
      flags_out <= flg_next;
    end
  end

endmodule

// File: bench/tb_eight_bit_alu_with_flags.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_eight_bit_alu_with_flags
// Drives command beats into the 8-bit ALU and checks every value and flag
// byte against an independent prediction of the Z80-style flag rules.
// Directed corner beats come first, then random beats with random gaps.
// ----------------------------------------------------------------------------
module tb_eight_bit_alu_with_flags;
  import ealu_pkg::*;

  localparam int unsigned RandomBeats   = 1200;
  localparam int unsigned WatchdogLimit = 2000;
  localparam int unsigned SettleCycles  = 8;
  localparam int unsigned DirectedCount = 26;
  localparam logic [CmdW-1:0] CmdUnused = 5'd31;

  // Expected results and the flag predictor
  class alu_scoreboard;
    typedef struct packed {
      byte_t value;
      byte_t flags;
    } alu_out_t;

    alu_out_t    expected_q[$];
    int unsigned errors;
    int unsigned checked;

    function void note_error(input string msg);
      errors++;
      if (errors <= 10) $display("MISMATCH: %s", msg);
    endfunction

    // S, Z, 5, 3 and even parity of a value
    function byte_t value_flags(input byte_t r);
      byte_t f;
      f        = '0;
      f[FlagS] = r[7];
      f[FlagZ] = (r == 8'h00);
      f[Flag5] = r[5];
      f[Flag3] = r[3];
      f[FlagP] = ~(^r);
      return f;
    endfunction

    // add with carry, or subtract with borrow
    function void arith(input byte_t a, input byte_t b, input logic cin, input logic sub,
                        output byte_t r, output byte_t f);
      byte_t      bb;
      logic       ci;
      logic [8:0] full;
      logic [4:0] half;
      bb   = sub ? ~b : b;
      ci   = sub ? ~cin : cin;
      full = {1'b0, a} + {1'b0, bb} + {8'd0, ci};
      half = {1'b0, a[3:0]} + {1'b0, bb[3:0]} + {4'd0, ci};
      r    = full[7:0];
      f        = '0;
      f[FlagS] = r[7];
      f[FlagZ] = (r == 8'h00);
      f[Flag5] = r[5];
      f[Flag3] = r[3];
      f[FlagH] = half[4] ^ sub;
      f[FlagP] = ~(a[7] ^ bb[7]) & (a[7] ^ r[7]);
      f[FlagN] = sub;
      f[FlagC] = full[8] ^ sub;
    endfunction

    function void alu_compute(input logic [CmdW-1:0] cmd, input byte_t a, input byte_t b,
                              input byte_t fin, output byte_t r, output byte_t f);
      logic       cin;
      logic       right;
      logic       out_bit;
      logic [4:0] k5;
      rot_t       kind;
      byte_t      v;
      byte_t      scratch;
      cin = fin[FlagC];
      r   = a;
      f   = fin;
      case (cmd)
        CMD_ADD: arith(a, b, 1'b0, 1'b0, r, f);
        CMD_ADC: arith(a, b, cin, 1'b0, r, f);
        CMD_SUB: arith(a, b, 1'b0, 1'b1, r, f);
        CMD_SBC: arith(a, b, cin, 1'b1, r, f);
        CMD_AND: begin
          r        = a & b;
          f        = value_flags(r);
          f[FlagH] = 1'b1;
        end
        CMD_XOR: begin
          r = a ^ b;
          f = value_flags(r);
        end
        CMD_OR: begin
          r = a | b;
          f = value_flags(r);
        end
        // compare: flags of a - b, bits 5 and 3 from the operand
        CMD_CP: begin
          arith(a, b, 1'b0, 1'b1, scratch, f);
          f[Flag5] = b[5];
          f[Flag3] = b[3];
          r        = a;
        end
        CMD_INC: begin
          r        = b + 8'd1;
          f        = value_flags(r);
          f[FlagH] = (r[3:0] == 4'h0);
          f[FlagP] = (r == 8'h80);
          f[FlagN] = 1'b0;
          f[FlagC] = cin;
        end
        CMD_DEC: begin
          r        = b - 8'd1;
          f        = value_flags(r);
          f[FlagH] = (r[3:0] == 4'hf);
          f[FlagP] = (r == 8'h7f);
          f[FlagN] = 1'b1;
          f[FlagC] = cin;
        end
        default: begin
          // rotates and shifts; codes past the accumulator group are no-ops
          if (cmd >= CMD_RLC && cmd <= CMD_RRA) begin
            k5      = (cmd >= CMD_RLCA) ? (cmd - CMD_RLCA) : (cmd - CMD_RLC);
            kind    = rot_t'(k5[2:0]);
            v       = (cmd >= CMD_RLCA) ? a : b;
            right   = k5[0];
            out_bit = right ? v[0] : v[7];
            r       = right ? {1'b0, v[7:1]} : {v[6:0], 1'b0};
            case (kind)
              ROT_RLC: r[0] = out_bit;
              ROT_RRC: r[7] = out_bit;
              ROT_RL:  r[0] = cin;
              ROT_RR:  r[7] = cin;
              ROT_SRA: r[7] = v[7];
              ROT_SLL: r[0] = 1'b1;
              default: ;
            endcase
            if (cmd >= CMD_RLCA) begin
              f        = '0;
              f[FlagS] = fin[FlagS];
              f[FlagZ] = fin[FlagZ];
              f[FlagP] = fin[FlagP];
              f[Flag5] = r[5];
              f[Flag3] = r[3];
            end else begin
              f = value_flags(r);
            end
            f[FlagC] = out_bit;
          end
        end
      endcase
    endfunction

    function void note_beat(input logic [CmdW-1:0] cmd, input byte_t a, input byte_t b,
                            input byte_t fin);
      alu_out_t e;
      alu_compute(cmd, a, b, fin, e.value, e.flags);
      expected_q.push_back(e);
    endfunction

    function void check_result(input byte_t value, input byte_t flags);
      alu_out_t e;
      if (expected_q.size() == 0) begin
        note_error($sformatf("result %h flags %h with no beat pending", value, flags));
        return;
      end
      e = expected_q.pop_front();
      checked++;
      if (value !== e.value)
        note_error($sformatf("result exp %h got %h", e.value, value));
      if (flags !== e.flags)
        note_error($sformatf("flags_out exp %b got %b (result %h)", e.flags, flags, value));
    endfunction
  endclass

  logic            clk       = 1'b0;
  logic            rst       = 1'b1;
  logic            start     = 1'b0;
  logic [CmdW-1:0] command   = '0;
  byte_t           acc_value = '0;
  byte_t           operand   = '0;
  byte_t           flags_in  = '0;
  logic            busy;
  logic            done;
  byte_t           result;
  byte_t           flags_out;

  alu_scoreboard board = new;
  int unsigned   beats_taken;
  int unsigned   quiet_cycles;
  int unsigned   cmd_seen [32];
  logic [28:0]   directed_beats [DirectedCount];

  eight_bit_alu_with_flags u_top (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .command   (command),
    .acc_value (acc_value),
    .operand   (operand),
    .flags_in  (flags_in),
    .done      (done),
    .result    (result),
    .flags_out (flags_out)
  );

  always #1 clk = ~clk;

  // present one beat and hold it until the block takes it
  task automatic send_beat(input logic [CmdW-1:0] cmd, input byte_t a, input byte_t b,
                           input byte_t fin);
    start     <= 1'b1;
    command   <= cmd;
    acc_value <= a;
    operand   <= b;
    flags_in  <= fin;
    do @(posedge clk); while (busy !== 1'b0);
  endtask

  task automatic idle_for(input int unsigned cycles);
    start <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  // random byte, leaning toward the corner values now and then
  function automatic byte_t rand_byte();
    int unsigned raw;
    raw = $urandom;
    case ($urandom_range(15))
      0:       return 8'h00;
      1:       return 8'hff;
      2:       return 8'h7f;
      3:       return 8'h80;
      default: return raw[7:0];
    endcase
  endfunction

  // monitor: take beats and results as they cross the clock edge
  always @(posedge clk) begin
    if (!rst && start && !busy) begin
      board.note_beat(command, acc_value, operand, flags_in);
      beats_taken++;
      cmd_seen[command]++;
    end
    if (!rst && done === 1'b1) board.check_result(result, flags_out);
    if (rst || (start && !busy) || done === 1'b1) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= WatchdogLimit) begin
      $display("tb_eight_bit_alu_with_flags: errors");
      $finish;
    end
  end

  initial begin
    int unsigned i;
    int unsigned roll;
    int unsigned gap;
    int unsigned sel;
    int unsigned distinct;
    logic [28:0] d;
    logic [CmdW-1:0] cmd;

    // corner beats: carries, overflow through carry-in, SBC zero, CP bits 5/3,
    // INC/DEC wrap points, SLL fill, accumulator rotates and an unused code
    directed_beats = '{
      {CMD_ADD,  8'hff, 8'h01, 8'h00},
      {CMD_ADC,  8'h7f, 8'h00, 8'h01},
      {CMD_SUB,  8'h00, 8'h01, 8'hff},
      {CMD_SBC,  8'h80, 8'h00, 8'h01},
      {CMD_SBC,  8'h01, 8'h00, 8'h01},
      {CMD_AND,  8'hff, 8'h00, 8'h00},
      {CMD_XOR,  8'h55, 8'hff, 8'hff},
      {CMD_OR,   8'h00, 8'h00, 8'hff},
      {CMD_CP,   8'h10, 8'h28, 8'h00},
      {CMD_INC,  8'h00, 8'h7f, 8'h00},
      {CMD_INC,  8'hff, 8'hff, 8'h01},
      {CMD_DEC,  8'h00, 8'h80, 8'h01},
      {CMD_DEC,  8'hff, 8'h00, 8'h00},
      {CMD_RLC,  8'h00, 8'h80, 8'h00},
      {CMD_RRC,  8'h00, 8'h01, 8'hff},
      {CMD_RL,   8'h00, 8'h80, 8'h01},
      {CMD_RR,   8'h00, 8'h01, 8'h01},
      {CMD_SLA,  8'h00, 8'hff, 8'h00},
      {CMD_SRA,  8'h00, 8'h80, 8'h00},
      {CMD_SLL,  8'h00, 8'h00, 8'h00},
      {CMD_SRL,  8'h00, 8'hff, 8'hff},
      {CMD_RLCA, 8'h81, 8'h00, 8'hc4},
      {CMD_RRCA, 8'h01, 8'hff, 8'hff},
      {CMD_RLA,  8'h80, 8'h00, 8'h00},
      {CMD_RRA,  8'h00, 8'h00, 8'h01},
      {CmdUnused, 8'ha5, 8'h3c, 8'h5a}
    };

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    for (i = 0; i < DirectedCount; i++) begin
      d = directed_beats[i];
      send_beat(d[28:24], d[23:16], d[15:8], d[7:0]);
    end

    // random beats; every few hundred a back-to-back stretch with no gaps
    for (i = 0; i < RandomBeats; i++) begin
      if ((i % 300) >= 60) begin
        roll = $urandom_range(99);
        if (roll < 55)      gap = 0;
        else if (roll < 88) gap = $urandom_range(3, 1);
        else if (roll < 97) gap = $urandom_range(10, 4);
        else                gap = $urandom_range(40, 15);
        if (gap != 0) idle_for(gap);
      end
      sel = ($urandom_range(19) == 0) ? $urandom_range(31, 22) : $urandom_range(21, 0);
      cmd = sel[CmdW-1:0];
      send_beat(cmd, rand_byte(), rand_byte(), rand_byte());
    end
    start <= 1'b0;

    // drain, then let the pipe settle
    while (board.expected_q.size() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);

    if (board.expected_q.size() != 0)
      board.note_error($sformatf("%0d results never arrived", board.expected_q.size()));

    distinct = 0;
    for (i = 0; i < 32; i++) if (cmd_seen[i] != 0) distinct++;
    $display("Covered %0d beats across %0d distinct command codes, %0d results checked.",
             beats_taken, distinct, board.checked);
    $display("Mismatch count: %0d", board.errors);

    if (board.errors == 0) begin
      $display("tb_eight_bit_alu_with_flags: clean");
    end else begin
      $display("tb_eight_bit_alu_with_flags: errors");
    end
    $finish;
  end

endmodule
